// ===== design/spkat_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spkat_pkg
// Shared types and codes for the sorted pair-key activation table.
// ----------------------------------------------------------------------------
package spkat_pkg;

    localparam logic OP_ACTIVATE = 1'b0;
    localparam logic OP_QUERY    = 1'b1;

    localparam logic [1:0] CODE_OK      = 2'd0;
    localparam logic [1:0] CODE_NOT_ACK = 2'd1;
    localparam logic [1:0] CODE_PREREQ  = 2'd2;
    localparam logic [1:0] CODE_FULL    = 2'd3;

    typedef struct packed {
        logic               op;
        logic        [63:0] primary_key;
        logic        [63:0] secondary_key;
        logic signed [63:0] activation_time;
        logic               acknowledged;
        logic               prereqs_met;
    } cmd_t;

    typedef struct packed {
        logic [1:0] result_code;
        logic       is_active;
        logic [6:0] entries_used;
    } result_t;

    typedef struct packed {
        logic [63:0] pk;
        logic [63:0] sk;
    } key_t;

    typedef struct packed {
        key_t               key;
        logic signed [63:0] tm;
    } entry_t;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic compare;
        logic insert;
        logic retime;
    } cell_ctrl_t;

endpackage : spkat_pkg
`default_nettype wire

// ===== design/spkat_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spkat_cell
// One table slot: holds an entry, compares it against the incoming key,
// takes its lower neighbor's entry or the new entry on insertion, and takes the new time on a retime.
// ----------------------------------------------------------------------------
module spkat_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CW    = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spkat_pkg::cell_ctrl_t  ctrl,
    input  spkat_pkg::key_t        key_in,
    input  spkat_pkg::entry_t      new_entry,
    input  spkat_pkg::entry_t      prev_entry,
    input  logic                   prev_below,
    input  logic [CW-1:0]          count,
    output spkat_pkg::entry_t      entry,
    output logic                   below,
    output logic                   eq
);
    import spkat_pkg::*;

    entry_t entry_reg;
    logic   below_reg;
    logic   eq_reg;
    logic   occupied;
    logic   pk_eq;
    logic   below_next;
    logic   eq_next;

    assign occupied   = CW'(INDEX) < count;
    assign pk_eq      = entry_reg.key.pk == key_in.pk;
    assign below_next = occupied && ((entry_reg.key.pk < key_in.pk) ||
                                     (pk_eq && (entry_reg.key.sk < key_in.sk)));
    assign eq_next    = occupied && pk_eq && (entry_reg.key.sk == key_in.sk);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            below_reg <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else if (ctrl.compare)
        begin
            below_reg <= below_next;
            eq_reg    <= eq_next;
        end
    end

    // shift up behind the insertion point, load the new entry at it; on a retime rewrite the matching entry's time
    always_ff @(posedge clk)
    begin
        if (ctrl.insert && !below_reg)
        begin
            entry_reg <= prev_below ? new_entry : prev_entry;
        end
        else if (ctrl.retime && eq_reg)
        begin
            entry_reg.tm <= new_entry.tm;
        end
    end

    assign entry = entry_reg;
    assign below = below_reg;
    assign eq    = eq_reg;

endmodule : spkat_cell
`default_nettype wire

// ===== design/sorted_pair_key_activation_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_pair_key_activation_table
// Sorted (primary, secondary) key table with activation times, built as a
// row of cells that compare in parallel and shift up on insertion.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the transfer happens at a
//   rising edge where start is high and busy is low. op selects activation
//   request or activity query.
//   Result channel: done pulses for exactly one cycle with result valid;
//   the receiver takes it at that edge and cannot hold it off.
//   Timing: the accept edge registers every cell's compare against the key;
//   the following cycle (busy high) shifts or rewrites cells and registers
//   the result, which appears with done. A new command is not taken while
//   busy is high, i.e. during the shift/write cycle of the cell row.
//   Configuration: APB register 0 (address 0) is capacity_in_use; write it
//   only while no command is in flight. pready is always high.
//   Reset: entry count clears to zero and capacity returns to 64. Cell
//   contents are not cleared; slots at or above the count are never used.
// ----------------------------------------------------------------------------
module sorted_pair_key_activation_table #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  spkat_pkg::cmd_t    cmd,
    output logic               done,
    output spkat_pkg::result_t result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import spkat_pkg::*;

    localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CMPW = (CW > 7) ? CW : 7;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [6:0]      cap_reg;
    cmd_t            cmd_reg;
    result_t         result_reg;
    result_t         result_next;
    logic            done_reg;

    logic            accept;
    logic            cfg_write;
    cell_ctrl_t      ctrl;
    entry_t          new_entry;
    entry_t          entries [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] below_flags;
    logic [TABLE_DEPTH-1:0] eq_flags;
    logic            hit;
    logic            full;
    logic [CMPW-1:0] cap_ext;
    logic [CMPW-1:0] cap_eff;
    logic [CMPW-1:0] count_ext;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == 2'd0);
    assign prdata    = (paddr == 2'd0) ? {25'd0, cap_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 7'd64;
        end
        else if (cfg_write)
        begin
            cap_reg <= pwdata[6:0];
        end
    end

    // ------------------------------------------------------------------
    // Command capture: cells compare on the accept edge, hold the command
    // for the shift/write cycle
    // ------------------------------------------------------------------
    assign busy   = (state_reg == ST_EXEC);
    assign accept = start && !busy;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
    end

    assign new_entry.key.pk = cmd_reg.primary_key;
    assign new_entry.key.sk = cmd_reg.secondary_key;
    assign new_entry.tm     = cmd_reg.activation_time;

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        entry_t prev_entry;
        logic   prev_below;

        if (i == 0)
        begin : g_first
            assign prev_entry = '0;
            assign prev_below = 1'b1;
        end
        else
        begin : g_rest
            assign prev_entry = entries[i-1];
            assign prev_below = below_flags[i-1];
        end

        spkat_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key_in     ('{pk: cmd.primary_key, sk: cmd.secondary_key}),
            .new_entry  (new_entry),
            .prev_entry (prev_entry),
            .prev_below (prev_below),
            .count      (count_reg),
            .entry      (entries[i]),
            .below      (below_flags[i]),
            .eq         (eq_flags[i])
        );
    end

    // ------------------------------------------------------------------
    // Decision in the shift/write cycle
    // ------------------------------------------------------------------
    assign hit       = |eq_flags;
    assign cap_ext   = CMPW'(cap_reg);
    assign cap_eff   = (cap_ext > CMPW'(TABLE_DEPTH)) ? CMPW'(TABLE_DEPTH) : cap_ext;
    assign count_ext = CMPW'(count_reg);
    assign full      = count_ext >= cap_eff;

    always_comb
    begin
        ctrl                     = '0;
        ctrl.compare             = accept;
        count_next               = count_reg;
        result_next.result_code  = CODE_OK;
        result_next.is_active    = 1'b0;
        if (state_reg == ST_EXEC)
        begin
            if (cmd_reg.op == OP_QUERY)
            begin
                result_next.is_active = hit;
            end
            else if (!cmd_reg.acknowledged)
            begin
                result_next.result_code = CODE_NOT_ACK;
            end
            else if (!cmd_reg.prereqs_met)
            begin
                result_next.result_code = CODE_PREREQ;
            end
            else if (hit)
            begin
                ctrl.retime = 1'b1;
            end
            else if (full)
            begin
                result_next.result_code = CODE_FULL;
            end
            else
            begin
                ctrl.insert = 1'b1;
                count_next  = count_reg + CW'(1);
            end
        end
        result_next.entries_used = 7'(count_next);
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == ST_EXEC);
        end
    end

    // register the result in the execute cycle and hold it until the next one
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_EXEC))
        else $error("result strobe without a preceding execute cycle");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(eq_flags))
        else $error("key pair matched in more than one cell");

    a_below_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((below_flags >> 1) & ~below_flags) == '0)
        else $error("cells below the key do not form a prefix; table unsorted");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_ext <= CMPW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(ctrl.insert))
        else $error("entry count changed without an insertion");
`endif

endmodule : sorted_pair_key_activation_table
`default_nettype wire
